[rtl/tdst_pkg.sv]
`timescale 1ns / 1ps

package tdst_pkg;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_FIND   = 2'd2,
    REQ_NOP    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_BAD_INDEX = 2'd2,
    STS_NONE      = 2'd3
  } status_e;

  localparam int unsigned MinPerHour = 60;
  localparam int unsigned MinPerDay  = 24 * 60;
  localparam int unsigned TimeW      = 11;
  localparam int unsigned InTdataW   = 56;
  localparam int unsigned OutTdataW  = 48;

  typedef struct packed {
    logic [7:0]  owner;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [15:0] amount;
  } slot_t;

  typedef struct packed {
    logic [5:0]  now_minute;
    logic [4:0]  now_hour;
    logic [5:0]  remove_index;
    logic [15:0] amount;
    logic [5:0]  slot_minute;
    logic [4:0]  slot_hour;
    logic [7:0]  owner_id;
  } req_fields_t;

  typedef struct packed {
    logic [15:0]      found_amount;
    logic [5:0]       found_minute;
    logic [4:0]       found_hour;
    logic [7:0]       found_owner;
    logic [TimeW-1:0] minutes_until;
  } res_fields_t;

  typedef struct packed {
    logic    capture;
    logic    add_wr;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    rem_start;
    logic    scan_start;
    logic    step_shift;
    logic    step_scan;
    logic    load_res;
    status_e res_status;
    logic    res_found;
  } cmd_t;

  typedef struct packed {
    req_e req_type;
    logic full;
    logic idx_bad;
    logic idx_last;
    logic empty;
    logic at_last;
    logic busy;
    logic out_busy;
  } sts_t;

  // hour * 60 + minute, then folded once into 0..1439
  function automatic logic [TimeW-1:0] day_time(input logic [4:0] hour,
                                                input logic [5:0] minute);
    logic [TimeW-1:0] h;
    logic [TimeW-1:0] t;
    h = TimeW'(hour);
    t = h * TimeW'(MinPerHour) + TimeW'(minute);
    if (t >= TimeW'(MinPerDay)) begin
      t = t - TimeW'(MinPerDay);
    end
    return t;
  endfunction

endpackage

[rtl/tdst_ctrl.sv]
`timescale 1ns / 1ps

module tdst_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  output logic          s_ready_o,
  input  tdst_pkg::sts_t sts_i,
  output tdst_pkg::cmd_t cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_EXEC  = 6'b000010,
    ST_SHIFT = 6'b000100,
    ST_SCAN  = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e              state_q, state_d;
  tdst_pkg::status_e   status_q, status_d;
  logic                found_q, found_d;

  assign s_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    found_d  = found_q;
    cmd_o    = '0;
    cmd_o.res_status = status_q;
    cmd_o.res_found  = found_q;
    case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        status_d = tdst_pkg::STS_OK;
        found_d  = 1'b0;
        state_d  = ST_DONE;
        case (sts_i.req_type)
          tdst_pkg::REQ_ADD: begin
            if (sts_i.full) begin
              status_d = tdst_pkg::STS_FULL;
            end else begin
              cmd_o.add_wr  = 1'b1;
              cmd_o.cnt_inc = 1'b1;
            end
          end
          tdst_pkg::REQ_REMOVE: begin
            if (sts_i.idx_bad) begin
              status_d = tdst_pkg::STS_BAD_INDEX;
            end else if (sts_i.idx_last) begin
              cmd_o.cnt_dec = 1'b1;
            end else begin
              cmd_o.rem_start = 1'b1;
              state_d = ST_SHIFT;
            end
          end
          tdst_pkg::REQ_FIND: begin
            if (sts_i.empty) begin
              status_d = tdst_pkg::STS_NONE;
            end else begin
              found_d = 1'b1;
              cmd_o.scan_start = 1'b1;
              state_d = ST_SCAN;
            end
          end
          default: begin
          end
        endcase
      end
      ST_SHIFT: begin
        cmd_o.step_shift = 1'b1;
        if (sts_i.at_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_SCAN: begin
        cmd_o.step_scan = 1'b1;
        if (sts_i.at_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts_i.busy) begin
          cmd_o.cnt_dec = (sts_i.req_type == tdst_pkg::REQ_REMOVE);
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.load_res = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      status_q <= tdst_pkg::STS_OK;
      found_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      found_q  <= found_d;
    end
  end

endmodule

[rtl/tdst_dp.sv]
`timescale 1ns / 1ps

module tdst_dp #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [tdst_pkg::InTdataW-1:0]        in_tdata_i,
  input  logic [1:0]                           in_tuser_i,
  input  tdst_pkg::cmd_t                       cmd_i,
  output tdst_pkg::sts_t                       sts_o,
  input  logic                                 out_tready_i,
  output logic                                 out_tvalid_o,
  output logic [tdst_pkg::OutTdataW-1:0]       out_tdata_o,
  output logic [1:0]                           out_tuser_o
);

  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned TW = tdst_pkg::TimeW;

  tdst_pkg::slot_t        mem [SLOTS];

  tdst_pkg::req_fields_t  req_q;
  tdst_pkg::req_e         req_type_q;
  logic [TW-1:0]          now_q;
  logic [CW-1:0]          cnt_q;
  logic [CW-1:0]          p_q;
  logic [AW-1:0]          wr_addr_q;
  tdst_pkg::slot_t        rd_q;
  logic                   rd_scan_q;
  logic                   rd_shift_q;
  tdst_pkg::slot_t        dist_slot_q;
  logic [TW-1:0]          dist_q;
  logic                   dist_vld_q;
  tdst_pkg::slot_t        best_slot_q;
  logic [TW-1:0]          best_d_q;
  logic                   have_q;
  logic                   out_vld_q;
  logic [1:0]             out_user_q;
  tdst_pkg::res_fields_t  out_data_q;

  tdst_pkg::req_fields_t  in_fields;
  logic [TW-1:0]          slot_t_now;
  logic signed [TW:0]     diff;
  logic [TW:0]            dist_wide;

  assign in_fields = tdst_pkg::req_fields_t'(in_tdata_i[$bits(tdst_pkg::req_fields_t)-1:0]);

  // distance 1..1440, slot at the current minute counts as a full day away
  assign slot_t_now = tdst_pkg::day_time(rd_q.hour, rd_q.minute);
  assign diff       = $signed({1'b0, slot_t_now}) - $signed({1'b0, now_q});
  assign dist_wide  = (diff[TW] || (diff == '0)) ? (TW + 1)'(diff + (TW + 1)'(tdst_pkg::MinPerDay))
                                                 : (TW + 1)'(diff);

  assign sts_o.req_type = req_type_q;
  assign sts_o.full     = (cnt_q >= CW'(SLOTS));
  assign sts_o.idx_bad  = (8'(req_q.remove_index) >= 8'(cnt_q));
  assign sts_o.idx_last = ((8'(req_q.remove_index) + 8'd1) == 8'(cnt_q));
  assign sts_o.empty    = (cnt_q == '0);
  assign sts_o.at_last  = (p_q == cnt_q - CW'(1));
  assign sts_o.busy     = rd_scan_q | rd_shift_q | dist_vld_q;
  assign sts_o.out_busy = out_vld_q & ~out_tready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_wr) begin
      mem[cnt_q[AW-1:0]] <= '{owner:  req_q.owner_id,
                              hour:   req_q.slot_hour,
                              minute: req_q.slot_minute,
                              amount: req_q.amount};
    end else if (rd_shift_q) begin
      mem[wr_addr_q] <= rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[p_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= in_fields;
      now_q <= tdst_pkg::day_time(in_fields.now_hour, in_fields.now_minute);
    end
    if (cmd_i.step_shift) begin
      wr_addr_q <= AW'(p_q - CW'(1));
    end
    dist_slot_q <= rd_q;
    dist_q      <= dist_wide[TW-1:0];
    if (dist_vld_q && (!have_q || dist_q < best_d_q)) begin
      best_slot_q <= dist_slot_q;
      best_d_q    <= dist_q;
    end
    if (cmd_i.load_res) begin
      out_user_q <= cmd_i.res_status;
      if (cmd_i.res_found) begin
        out_data_q <= '{found_amount:  best_slot_q.amount,
                        found_minute:  best_slot_q.minute,
                        found_hour:    best_slot_q.hour,
                        found_owner:   best_slot_q.owner,
                        minutes_until: best_d_q};
      end else begin
        out_data_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_type_q <= tdst_pkg::REQ_NOP;
      cnt_q      <= '0;
      p_q        <= '0;
      rd_scan_q  <= 1'b0;
      rd_shift_q <= 1'b0;
      dist_vld_q <= 1'b0;
      have_q     <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        req_type_q <= tdst_pkg::req_e'(in_tuser_i);
      end
      if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (cmd_i.cnt_dec) begin
        cnt_q <= cnt_q - CW'(1);
      end
      if (cmd_i.rem_start) begin
        p_q <= CW'(req_q.remove_index) + CW'(1);
      end else if (cmd_i.scan_start) begin
        p_q <= '0;
      end else if (cmd_i.step_shift || cmd_i.step_scan) begin
        p_q <= p_q + CW'(1);
      end
      rd_scan_q  <= cmd_i.step_scan;
      rd_shift_q <= cmd_i.step_shift;
      dist_vld_q <= rd_scan_q;
      if (cmd_i.scan_start) begin
        have_q <= 1'b0;
      end else if (dist_vld_q) begin
        have_q <= 1'b1;
      end
      if (cmd_i.load_res) begin
        out_vld_q <= 1'b1;
      end else if (out_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_tvalid_o = out_vld_q;
  assign out_tuser_o  = out_user_q;
  assign out_tdata_o  = tdst_pkg::OutTdataW'(out_data_q);

endmodule

[rtl/time_of_day_slot_table.sv]
`timescale 1ns / 1ps
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid_i/s_axis_tready_o request: tuser = req_type, tdata = fields
// m_axis    out  m_axis_tvalid_o/m_axis_tready_i result:  tuser = status,   tdata = fields
//
// One request at a time. Add, a bad remove, a remove of the last entry and a find in an
// empty table go straight to the result. Remove at index i shifts the entries above i
// down and find next scans every entry; the slot memory has one read port, read once
// per cycle per entry. Reset empties the table at once; entries past the count go unused.
// A held result stalls only the final step; the next request is accepted meanwhile.

module time_of_day_slot_table #(
  parameter int unsigned SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // owner_id, slot_hour, slot_minute, amount, remove_index, now_hour, now_minute
  input  logic [55:0] s_axis_tdata_i,
  // req_type
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // minutes_until, found_owner, found_hour, found_minute, found_amount
  output logic [47:0] m_axis_tdata_o,
  // status
  output logic [1:0]  m_axis_tuser_o
);

  tdst_pkg::cmd_t cmd;
  tdst_pkg::sts_t sts;

  tdst_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  tdst_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_tdata_i   (s_axis_tdata_i),
    .in_tuser_i   (s_axis_tuser_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_tready_i (m_axis_tready_i),
    .out_tvalid_o (m_axis_tvalid_o),
    .out_tdata_o  (m_axis_tdata_o),
    .out_tuser_o  (m_axis_tuser_o)
  );

endmodule
